>>> hdl/liup_pkg.sv
// Shared types, constants and codes for the linear interpolation upsampler.
package liup_pkg;

    // Fixed widths of the interface fields.
    localparam int FIELD_BITS      = 16;
    localparam int RATIO_FIELD     = 7;
    localparam int CFG_INDEX_BITS  = 2;

    // Gain format and reset values.
    localparam int GAIN_FRAC       = 12;
    localparam logic signed [FIELD_BITS-1:0] GAIN_UNITY = 16'sd4096;

    // Defaults for the top-level parameters.
    localparam int MAX_RATIO_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STRETCH_RATIO = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN          = 2'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIV,
        ST_RUN
    } state_t;

    // Input word.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] sample_in;
        logic                         stream_start;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic signed [FIELD_BITS-1:0] sample_out;
        logic                         last_of_run;
    } out_word_t;

endpackage

>>> hdl/liup_cmpsub.sv
// Shared compare-and-subtract unit used for both division steps and run steps.
module liup_cmpsub #(
    parameter int W = 8
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         ge,
    output logic [W-1:0] diff
);

    // One wide subtract; the borrow tells whether a is at least b.
    logic [W:0] sub;

    assign sub  = {1'b0, a} - {1'b0, b};
    assign ge   = ~sub[W];
    assign diff = sub[W-1:0];

endmodule

>>> hdl/liup_scale.sv
// Gain multiplier with floor shift and saturation of the scaled sample.
module liup_scale #(
    parameter int SAMPLE_BITS = liup_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic signed [SAMPLE_BITS-1:0]          sample,
    input  logic signed [liup_pkg::FIELD_BITS-1:0] gain,
    output logic signed [SAMPLE_BITS-1:0]          scaled
);

    localparam int PW = SAMPLE_BITS + liup_pkg::FIELD_BITS;
    localparam int SW = PW - liup_pkg::GAIN_FRAC;

    logic signed [PW-1:0] sample_ext;
    logic signed [PW-1:0] gain_ext;
    logic signed [PW-1:0] prod_reg;
    logic signed [SW-1:0] shifted;
    logic                 in_range;

    assign sample_ext = PW'(sample);
    assign gain_ext   = PW'(gain);

    // The product is registered before the shift and saturation.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= sample_ext * gain_ext;
        end
    end

    // Dropping the fraction bits of a two's complement value rounds toward minus infinity.
    assign shifted  = prod_reg[PW-1:liup_pkg::GAIN_FRAC];
    assign in_range = (shifted[SW-1:SAMPLE_BITS-1] == '0) || (shifted[SW-1:SAMPLE_BITS-1] == '1);

    // Saturate to the signed sample range.
    always_comb
    begin
        if (in_range)
        begin
            scaled = shifted[SAMPLE_BITS-1:0];
        end
        else if (shifted[SW-1])
        begin
            scaled = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            scaled = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

>>> hdl/linear_interp_upsampler_top.sv
// Top level of the linear interpolation upsampler: sequencer, datapath and ports.
//
// Each accepted word is scaled by the Q4.12 gain and, unless it starts a stream,
// produces stretch_ratio interpolated words from the previous scaled sample to
// the new one. An item occupies the block for one multiply, SAMPLE_BITS + 1
// restoring division steps of |x - p| by the ratio, one output word per cycle
// while the output is not stalled, and a return to idle to take the next word;
// a stream-start word takes only the multiply. The single compare-and-subtract
// unit is why the steps run in series: it performs every division step and then
// the remainder correction for each output word. The input is stalled for the
// whole of that time; output stalls lengthen it.
module linear_interp_upsampler_top #(
    parameter int MAX_RATIO   = liup_pkg::MAX_RATIO_DEF,
    parameter int SAMPLE_BITS = liup_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  liup_pkg::in_word_t                         in_word,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output liup_pkg::out_word_t                        out_word,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [liup_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [liup_pkg::FIELD_BITS-1:0]            cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int RB  = $clog2(MAX_RATIO + 1);
    localparam int AW  = RB + 1;
    localparam int DCW = $clog2(SB + 1);
    localparam int EXT = SB + liup_pkg::FIELD_BITS;

    liup_pkg::state_t state_reg;
    liup_pkg::state_t state_next;

    // Configuration registers.
    logic [RB-1:0]                            ratio_reg;
    logic signed [liup_pkg::FIELD_BITS-1:0]   gain_reg;
    logic [liup_pkg::RATIO_FIELD-1:0]         ratio_field;
    logic [RB-1:0]                            ratio_clamped;

    // Sample state.
    logic signed [SB-1:0] x_in;
    logic [EXT-1:0]       raw_ext;
    logic signed [SB-1:0] scaled;
    logic signed [SB-1:0] p_reg;
    logic                 pvalid_reg;
    logic                 start_reg;
    logic signed [SB-1:0] p_run_reg;
    logic                 neg_reg;

    // Division and run registers.
    logic [SB:0]     dq_reg;
    logic [RB-1:0]   rem_reg;
    logic [RB-1:0]   rd_reg;
    logic [DCW-1:0]  dcnt_reg;
    logic [SB:0]     acc_q_reg;
    logic [RB-1:0]   k_reg;

    // Shared unit connections.
    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    logic          alu_ge;
    logic [AW-1:0] alu_diff;
    logic [RB-1:0] rem_step;

    // Control strobes.
    logic in_accept;
    logic out_load;
    logic run_last;
    logic div_done;
    logic no_run;

    // Interpolation arithmetic.
    logic signed [SB:0]   diff_d;
    logic [SB:0]          abs_d;
    logic [SB:0]          q_new;
    logic signed [SB+1:0] p_ext;
    logic signed [SB+1:0] q_ext;
    logic signed [SB+1:0] y_full;
    logic signed [SB-1:0] y_s;
    logic signed [EXT-1:0] y_ext;

    // Output register.
    logic                 out_valid_reg;
    liup_pkg::out_word_t  out_word_reg;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // The low SAMPLE_BITS bits of the input field are taken as two's complement.
    assign raw_ext = EXT'($unsigned(in_word.sample_in));
    assign x_in    = raw_ext[SB-1:0];

    liup_scale #(
        .SAMPLE_BITS (SB)
    ) u_scale (
        .clk    (clk),
        .load   (in_accept),
        .sample (x_in),
        .gain   (gain_reg),
        .scaled (scaled)
    );

    // Ratio writes are clamped into 1 .. MAX_RATIO.
    assign ratio_field = cfg_data[liup_pkg::RATIO_FIELD-1:0];

    always_comb
    begin
        if (ratio_field == '0)
        begin
            ratio_clamped = RB'(1);
        end
        else if (32'(ratio_field) > MAX_RATIO)
        begin
            ratio_clamped = RB'(MAX_RATIO);
        end
        else
        begin
            ratio_clamped = RB'(ratio_field);
        end
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RB'(1);
            gain_reg  <= liup_pkg::GAIN_UNITY;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                liup_pkg::CFG_STRETCH_RATIO: ratio_reg <= ratio_clamped;
                liup_pkg::CFG_GAIN:          gain_reg  <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Shared unit operands: a division step, or the remainder sum of a run step.
    always_comb
    begin
        if (state_reg == liup_pkg::ST_DIV)
        begin
            alu_a = {rem_reg, dq_reg[SB]};
        end
        else
        begin
            alu_a = AW'(rem_reg) + AW'(rd_reg);
        end
    end

    assign alu_b = AW'(ratio_reg);

    liup_cmpsub #(
        .W (AW)
    ) u_cmpsub (
        .a    (alu_a),
        .b    (alu_b),
        .ge   (alu_ge),
        .diff (alu_diff)
    );

    assign rem_step = alu_ge ? alu_diff[RB-1:0] : alu_a[RB-1:0];

    // Difference between the new scaled sample and the previous one.
    assign diff_d = SB'(0) + ((SB+1)'(scaled) - (SB+1)'(p_reg));
    assign abs_d  = diff_d[SB] ? $unsigned(-diff_d) : $unsigned(diff_d);

    // Run step: quotient grows by |d| / r plus a carry from the remainder.
    assign q_new  = acc_q_reg + dq_reg + (SB+1)'(alu_ge);
    assign p_ext  = (SB+2)'(p_run_reg);
    assign q_ext  = $signed((SB+2)'(q_new));
    assign y_full = neg_reg ? (p_ext - q_ext) : (p_ext + q_ext);
    assign y_s    = y_full[SB-1:0];
    assign y_ext  = EXT'(y_s);

    // Sequencer control strobes.
    always_comb
    begin
        in_stall = (state_reg != liup_pkg::ST_IDLE);
        in_accept = in_valid && (state_reg == liup_pkg::ST_IDLE);
        out_load = (state_reg == liup_pkg::ST_RUN) && (!out_valid_reg || !out_stall);
        run_last = (k_reg == ratio_reg);
        div_done = (dcnt_reg == DCW'(SB));
        no_run   = start_reg || !pvalid_reg;
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            liup_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = liup_pkg::ST_SCALE;
                end
            end
            liup_pkg::ST_SCALE:
            begin
                state_next = no_run ? liup_pkg::ST_IDLE : liup_pkg::ST_DIV;
            end
            liup_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = liup_pkg::ST_RUN;
                end
            end
            liup_pkg::ST_RUN:
            begin
                if (out_load && run_last)
                begin
                    state_next = liup_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = liup_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= liup_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Stream state: previous sample and whether it belongs to a live stream.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg      <= '0;
            pvalid_reg <= 1'b0;
        end
        else if (state_reg == liup_pkg::ST_SCALE)
        begin
            p_reg      <= scaled;
            pvalid_reg <= 1'b1;
        end
    end

    // Datapath registers for division and the output run.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            start_reg <= in_word.stream_start;
        end

        unique case (state_reg)
            liup_pkg::ST_SCALE:
            begin
                p_run_reg <= p_reg;
                neg_reg   <= diff_d[SB];
                dq_reg    <= abs_d;
                rem_reg   <= '0;
                dcnt_reg  <= '0;
            end
            liup_pkg::ST_DIV:
            begin
                dq_reg   <= {dq_reg[SB-1:0], alu_ge};
                dcnt_reg <= dcnt_reg + DCW'(1);
                if (div_done)
                begin
                    rd_reg    <= rem_step;
                    rem_reg   <= '0;
                    acc_q_reg <= '0;
                    k_reg     <= RB'(1);
                end
                else
                begin
                    rem_reg <= rem_step;
                end
            end
            liup_pkg::ST_RUN:
            begin
                if (out_load)
                begin
                    acc_q_reg <= q_new;
                    rem_reg   <= rem_step;
                    k_reg     <= k_reg + RB'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register: holds a word until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg.sample_out  <= y_ext[liup_pkg::FIELD_BITS-1:0];
            out_word_reg.last_of_run <= run_last;
        end
    end

endmodule

>>> hdl/liup_checker.sv
// Port-level checks for the upsampler top level, with the bind that attaches them.
module liup_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input liup_pkg::in_word_t                  in_word,
    input logic                                out_valid,
    input logic                                out_stall,
    input liup_pkg::out_word_t                 out_word,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [liup_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input logic [liup_pkg::FIELD_BITS-1:0]     cfg_data
);

    // A stalled output word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

    // An accepted word keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken on two consecutive cycles");

    // While a run is unfinished no new input may be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.last_of_run |-> in_stall)
    else $error("input ready in the middle of a run");

    // Configuration writes are always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind linear_interp_upsampler_top liup_checker u_liup_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the linear interpolation upsampler.
`timescale 1ns / 1ps

module tb_top;

    // Register indexes that the block does not decode.
    localparam logic [liup_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [liup_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    localparam int SAT_HI       = 32767;
    localparam int SAT_LO       = -32768;
    localparam int SETTLE_TICKS = 8;
    localparam int TAIL_TICKS   = 120;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  in_valid;
    logic                                  in_stall;
    liup_pkg::in_word_t                    in_word;
    logic                                  out_valid;
    logic                                  out_stall;
    liup_pkg::out_word_t                   out_word;
    logic                                  cfg_valid;
    logic                                  cfg_ready;
    logic [liup_pkg::CFG_INDEX_BITS-1:0]   cfg_index;
    logic [liup_pkg::FIELD_BITS-1:0]       cfg_data;

    // Software copy of the block's registers and stream state.
    int                        model_ratio;
    logic signed [15:0]        model_gain;
    logic signed [15:0]        model_prev;
    logic                      model_primed;

    // Interpolated words still to come out of the block, oldest first.
    liup_pkg::out_word_t       upcoming[$];
    liup_pkg::out_word_t       want;

    int                        mismatches;
    int                        cycle_count;
    int                        offer_gap_pct;
    int                        stall_pct;
    int                        hold_request;
    int                        hold_left;

    linear_interp_upsampler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gain stage: Q4.12 multiply, floor shift and saturation to 16 bits.
    function automatic logic signed [15:0] apply_gain(input logic signed [15:0] s);
        logic signed [31:0] prod;
        prod = 32'(s) * 32'(model_gain);
        prod = prod >>> liup_pkg::GAIN_FRAC;
        if (prod > SAT_HI)
            return SAT_HI[15:0];
        if (prod < SAT_LO)
            return SAT_LO[15:0];
        return prod[15:0];
    endfunction

    // Works out the run of interpolated words that one accepted word causes.
    function automatic void predict_run(input liup_pkg::in_word_t w);
        logic signed [15:0]  scaled;
        int                  p_i;
        int                  x_i;
        int                  d_i;
        int                  y_i;
        liup_pkg::out_word_t o;
        scaled     = apply_gain(w.sample_in);
        p_i        = int'(model_prev);
        x_i        = int'(scaled);
        d_i        = x_i - p_i;
        model_prev = scaled;
        if (w.stream_start || !model_primed)
        begin
            model_primed = 1'b1;
            return;
        end
        for (int k = 1; k <= model_ratio; k++)
        begin
            // Integer division in SystemVerilog truncates toward zero.
            y_i           = p_i + (d_i * k) / model_ratio;
            o.sample_out  = y_i[15:0];
            o.last_of_run = (k == model_ratio);
            upcoming.push_back(o);
        end
    endfunction

    // Offers one word, with random gaps beforehand, and waits until it is taken.
    task automatic send_sample(input logic signed [15:0] value, input logic begin_stream);
        while ($urandom_range(99) < offer_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid             = 1'b1;
        in_word.sample_in    = value;
        in_word.stream_start = begin_stream;
        do
            @(posedge clk);
        while (in_stall);
        predict_run(in_word);
        @(negedge clk);
    endtask

    // Waits until every predicted word has come out and the block has gone quiet.
    task automatic settle_block();
        in_valid = 1'b0;
        while (upcoming.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    // Writes one register and mirrors the write into the software copy.
    task automatic write_reg(input logic [liup_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [liup_pkg::FIELD_BITS-1:0] value);
        int r;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            liup_pkg::CFG_STRETCH_RATIO:
            begin
                r = int'(value[liup_pkg::RATIO_FIELD-1:0]);
                if (r < 1)
                    r = 1;
                if (r > liup_pkg::MAX_RATIO_DEF)
                    r = liup_pkg::MAX_RATIO_DEF;
                model_ratio = r;
            end
            liup_pkg::CFG_GAIN:
                model_gain = value;
            default:
                ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random sample with extra weight on the full-scale values and zero.
    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] v;
        case ($urandom_range(7))
            0: v = 16'sh7fff;
            1: v = 16'sh8000;
            2: v = 16'sh0000;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // Default registers after reset: unity gain, one word per input, first word primes.
    task automatic test_power_on();
        send_sample(-16'sd100, 1'b0);
        send_sample(16'sd2000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
    endtask

    // Ratio writes outside the legal range, and writes to undecoded indexes.
    task automatic test_register_clamps();
        settle_block();
        write_reg(liup_pkg::CFG_STRETCH_RATIO, 16'h0000);
        send_sample(16'sd100, 1'b0);
        settle_block();
        write_reg(liup_pkg::CFG_STRETCH_RATIO, 16'h007f);
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b0);
        settle_block();
        write_reg(liup_pkg::CFG_STRETCH_RATIO, 16'h0080);
        send_sample(16'sd5, 1'b0);
        settle_block();
        write_reg(liup_pkg::CFG_STRETCH_RATIO, 16'hffc1);
        send_sample(-16'sd7, 1'b0);
        settle_block();
        write_reg(CFG_SPARE_2, 16'hffff);
        write_reg(CFG_SPARE_3, 16'h0000);
        send_sample(16'sd1234, 1'b0);
    endtask

    // Gain extremes, saturation, floor rounding of negatives and restarts mid-stream.
    task automatic test_gain_edges();
        settle_block();
        write_reg(liup_pkg::CFG_STRETCH_RATIO, 16'd2);
        write_reg(liup_pkg::CFG_GAIN, 16'h7fff);
        send_sample(16'sh7fff, 1'b1);
        send_sample(16'sh8000, 1'b0);
        settle_block();
        write_reg(liup_pkg::CFG_GAIN, 16'h8000);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        settle_block();
        write_reg(liup_pkg::CFG_GAIN, 16'h0000);
        send_sample(16'sd12345, 1'b0);
        settle_block();
        write_reg(liup_pkg::CFG_GAIN, 16'hffff);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        settle_block();
        write_reg(liup_pkg::CFG_GAIN, liup_pkg::GAIN_UNITY);
        send_sample(16'sd300, 1'b1);
        send_sample(-16'sd300, 1'b0);
    endtask

    // One phase of random streams under a given setting and idling pattern.
    task automatic run_phase(input logic [15:0] raw_ratio, input logic [15:0] raw_gain,
                             input int gap_pct, input int hold_pct, input int count);
        settle_block();
        write_reg(liup_pkg::CFG_STRETCH_RATIO, raw_ratio);
        write_reg(liup_pkg::CFG_GAIN, raw_gain);
        offer_gap_pct = gap_pct;
        stall_pct     = hold_pct;
        // Mostly long streams, each begun with a start word.
        send_sample(pick_sample(), 1'b1);
        for (int n = 1; n < count; n++)
            send_sample(pick_sample(), ($urandom_range(11) == 0));
    endtask

    task automatic test_random_streams();
        logic [15:0] g;
        run_phase(16'd3, liup_pkg::GAIN_UNITY, 0, 0, 35);
        run_phase(16'd64, 16'($urandom), 64, 0, 35);
        g = 16'($urandom_range(16384) - 8192);
        run_phase(16'($urandom), g, 0, 64, 35);
        g = 16'($urandom_range(6144) + 1024);
        run_phase(16'($urandom_range(12, 2)), g, 11, 11, 35);
    endtask

    // The receiver holds off for a long stretch while words keep being offered.
    task automatic test_output_backpressure();
        settle_block();
        write_reg(liup_pkg::CFG_STRETCH_RATIO, 16'd8);
        write_reg(liup_pkg::CFG_GAIN, liup_pkg::GAIN_UNITY);
        offer_gap_pct = 0;
        stall_pct     = 0;
        hold_request  = 400;
        send_sample(pick_sample(), 1'b1);
        for (int n = 0; n < 12; n++)
            send_sample(pick_sample(), 1'b0);
        stall_pct = 20;
        for (int n = 0; n < 8; n++)
            send_sample(pick_sample(), 1'b0);
    endtask

    // Receiver: random stalls, or a long hold-off counted down here.
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each word taken from the output with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (upcoming.size() == 0)
            begin
                $error("unexpected word: sample_out %0d last_of_run %0b",
                       out_word.sample_out, out_word.last_of_run);
                mismatches++;
            end
            else
            begin
                want = upcoming.pop_front();
                if (out_word.sample_out !== want.sample_out)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           want.sample_out, out_word.sample_out);
                    mismatches++;
                end
                if (out_word.last_of_run !== want.last_of_run)
                begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last_of_run, out_word.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[linear_interp_upsampler_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_word       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = liup_pkg::CFG_STRETCH_RATIO;
        cfg_data      = '0;
        mismatches    = 0;
        cycle_count   = 0;
        offer_gap_pct = 0;
        stall_pct     = 0;
        hold_request  = 0;
        hold_left     = 0;
        model_ratio   = 1;
        model_gain    = liup_pkg::GAIN_UNITY;
        model_prev    = '0;
        model_primed  = 1'b0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_power_on();
        test_register_clamps();
        test_gain_edges();
        test_random_streams();
        test_output_backpressure();

        settle_block();
        repeat (TAIL_TICKS) @(negedge clk);
        if (upcoming.size() != 0)
        begin
            $error("%0d predicted words never came out", upcoming.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[linear_interp_upsampler_top] OK");
        else
            $display("[linear_interp_upsampler_top] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/liup_pkg.sv
hdl/liup_cmpsub.sv
hdl/liup_scale.sv
hdl/linear_interp_upsampler_top.sv
hdl/liup_checker.sv
tb/tb_top.sv
